// File: hdl/arc_point_normalized_lerp_defines.svh
// Assertion macros shared by the arc point block.
`ifndef ARC_POINT_NORMALIZED_LERP_DEFINES_SVH
`define ARC_POINT_NORMALIZED_LERP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define APNL_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define APNL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/apnl_pkg.sv
package apnl_pkg;

  localparam int COORD_W      = 20;
  localparam int IDX_W        = 10;
  localparam int CFG_IDX_W    = 3;
  localparam int STAT_W       = 2;
  localparam int KIND_W       = 3;
  localparam int NCOORD       = 3;
  localparam int PROD_W       = 31;
  localparam int VEC_W        = 32;
  localparam int MAG_W        = 30;
  localparam int MSQ_W        = 60;
  localparam int LEN_W        = 62;
  localparam int RM_W         = 50;
  localparam int HALF_W       = 25;
  localparam int HSQ_W        = 50;
  localparam int T_W          = 100;
  localparam int Q_W          = 20;
  localparam int QL_W         = 82;
  localparam int ACC_W        = 103;
  localparam int FRONT_STAGES = 5;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DEGEN = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ARC   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START = 3'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RANGE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEGEN = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END_Z   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGS    = 3'd7;

  localparam logic [IDX_W-1:0]   SEG_RESET     = 10'd100;
  localparam logic [Q_W-1:0]     POS_MAG_MAX   = 20'h7FFFF;
  localparam logic [Q_W-1:0]     NEG_MAG_MAX   = 20'h80000;

  typedef struct packed {
    logic [NCOORD-1:0][COORD_W-1:0] start_pt;
    logic [NCOORD-1:0][COORD_W-1:0] end_pt;
    logic [COORD_W-1:0]             radius;
    logic [IDX_W-1:0]               segment_count;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              is_final;
    logic [NCOORD-1:0] neg;
  } ctl_t;

  typedef logic [NCOORD-1:0][T_W-1:0] tvec_t;
  typedef logic [NCOORD-1:0][Q_W-1:0] qvec_t;

endpackage

// File: hdl/apnl_in_if.sv
interface apnl_in_if import apnl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] step_index;

  modport source (output valid, step_index, input ready);
  modport sink (input valid, step_index, output ready);
endinterface

// File: hdl/apnl_out_if.sv
interface apnl_out_if import apnl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic [STAT_W-1:0]         point_status;
  logic                      is_final;

  modport source (output valid, point_x, point_y, point_z, point_status, is_final,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, point_status, is_final,
                output ready);
endinterface

// File: hdl/apnl_front.sv
module apnl_front import apnl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IDX_W-1:0] step_index,
  output logic             out_valid,
  input  logic             out_ready,
  output ctl_t             out_ctl,
  output logic [LEN_W-1:0] out_len2,
  output tvec_t            out_t
);

  logic [FRONT_STAGES:1] v;
  logic [FRONT_STAGES:1] en;

  always_comb begin
    en[FRONT_STAGES] = !v[FRONT_STAGES] || out_ready;
    for (int s = FRONT_STAGES - 1; s >= 1; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      for (int s = 2; s <= FRONT_STAGES; s++) begin
        if (en[s]) v[s] <= v[s-1];
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v[FRONT_STAGES];

  // stage 1: weights and endpoint products
  logic [IDX_W-1:0] wa;
  ctl_t             ctl0;
  assign wa = cfg.segment_count - step_index;

  always_comb begin
    ctl0.is_final = (step_index == cfg.segment_count);
    ctl0.neg      = '0;
    if (step_index == '0) begin
      ctl0.kind = KIND_START;
    end else if (step_index == cfg.segment_count) begin
      ctl0.kind = KIND_END;
    end else if (step_index > cfg.segment_count) begin
      ctl0.kind = KIND_RANGE;
    end else begin
      ctl0.kind = KIND_ARC;
    end
  end

  ctl_t                             ctl1;
  logic signed [NCOORD-1:0][PROD_W-1:0] pa1, pb1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ctl1 <= ctl0;
      for (int c = 0; c < NCOORD; c++) begin
        pa1[c] <= $signed({1'b0, wa}) * $signed(cfg.start_pt[c]);
        pb1[c] <= $signed({1'b0, step_index}) * $signed(cfg.end_pt[c]);
      end
    end
  end

  // stage 2: direction and magnitude
  ctl_t                          ctl2;
  logic [NCOORD-1:0][MAG_W-1:0]  mag2;
  logic signed [VEC_W-1:0]       vsum [NCOORD];
  logic signed [VEC_W-1:0]       vabs [NCOORD];

  always_comb begin
    for (int c = 0; c < NCOORD; c++) begin
      vsum[c] = VEC_W'($signed(pa1[c])) + VEC_W'($signed(pb1[c]));
      vabs[c] = vsum[c][VEC_W-1] ? -vsum[c] : vsum[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ctl2.kind     <= ctl1.kind;
      ctl2.is_final <= ctl1.is_final;
      for (int c = 0; c < NCOORD; c++) begin
        ctl2.neg[c] <= vsum[c][VEC_W-1];
        mag2[c]     <= vabs[c][MAG_W-1:0];
      end
    end
  end

  // stage 3: squares and radius products
  ctl_t                         ctl3;
  logic [NCOORD-1:0][MSQ_W-1:0] msq3;
  logic [NCOORD-1:0][RM_W-1:0]  rm3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ctl3 <= ctl2;
      for (int c = 0; c < NCOORD; c++) begin
        msq3[c] <= MSQ_W'(mag2[c]) * MSQ_W'(mag2[c]);
        rm3[c]  <= RM_W'(cfg.radius) * RM_W'(mag2[c]);
      end
    end
  end

  // stage 4: length squared, split squares of radius products
  ctl_t                         ctl4;
  logic [LEN_W-1:0]             len4;
  logic [LEN_W-1:0]             len_sum;
  logic [NCOORD-1:0][HSQ_W-1:0] hh4, hl4, ll4;

  assign len_sum = LEN_W'(msq3[0]) + LEN_W'(msq3[1]) + LEN_W'(msq3[2]);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      ctl4.kind     <= (ctl3.kind == KIND_ARC && len_sum == '0) ? KIND_DEGEN : ctl3.kind;
      ctl4.is_final <= ctl3.is_final;
      ctl4.neg      <= ctl3.neg;
      len4 <= len_sum;
      for (int c = 0; c < NCOORD; c++) begin
        hh4[c] <= HSQ_W'(rm3[c][RM_W-1:HALF_W]) * HSQ_W'(rm3[c][RM_W-1:HALF_W]);
        hl4[c] <= HSQ_W'(rm3[c][RM_W-1:HALF_W]) * HSQ_W'(rm3[c][HALF_W-1:0]);
        ll4[c] <= HSQ_W'(rm3[c][HALF_W-1:0]) * HSQ_W'(rm3[c][HALF_W-1:0]);
      end
    end
  end

  // stage 5: target (radius * |v_c|)^2
  always_ff @(posedge clk) begin
    if (en[5]) begin
      out_ctl  <= ctl4;
      out_len2 <= len4;
      for (int c = 0; c < NCOORD; c++) begin
        out_t[c] <= (T_W'(hh4[c]) << (2 * HALF_W)) + (T_W'(hl4[c]) << (HALF_W + 1))
                    + T_W'(ll4[c]);
      end
    end
  end

endmodule

// File: hdl/apnl_search.sv
`include "arc_point_normalized_lerp_defines.svh"

module apnl_search import apnl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [COORD_W-1:0] radius,
  input  logic               in_valid,
  output logic               in_ready,
  input  ctl_t               in_ctl,
  input  logic [LEN_W-1:0]   in_len2,
  input  tvec_t              in_t,
  output logic               out_valid,
  input  logic               out_ready,
  output ctl_t               out_ctl,
  output qvec_t              out_q
);

  // one quotient bit per stage: largest q with q^2 * len2 <= t
  logic [Q_W:1] v;
  logic [Q_W:1] en;

  ctl_t                         ctl_r [1:Q_W];
  logic [LEN_W-1:0]             len_r [1:Q_W];
  tvec_t                        t_r   [1:Q_W];
  logic [NCOORD-1:0][ACC_W-1:0] acc_r [1:Q_W];
  logic [NCOORD-1:0][QL_W-1:0]  ql_r  [1:Q_W];
  qvec_t                        q_r   [1:Q_W];

  always_comb begin
    en[Q_W] = !v[Q_W] || out_ready;
    for (int s = Q_W - 1; s >= 1; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      for (int s = 2; s <= Q_W; s++) begin
        if (en[s]) v[s] <= v[s-1];
      end
    end
  end

  for (genvar s = 1; s <= Q_W; s++) begin : g_step
    localparam int J = Q_W - s;

    ctl_t                         ctl_i;
    logic [LEN_W-1:0]             len_i;
    tvec_t                        t_i;
    logic [NCOORD-1:0][ACC_W-1:0] acc_i, acc_n;
    logic [NCOORD-1:0][QL_W-1:0]  ql_i, ql_n;
    qvec_t                        q_i, q_n;
    logic [NCOORD-1:0][ACC_W-1:0] cand;

    if (s == 1) begin : g_first
      assign ctl_i = in_ctl;
      assign len_i = in_len2;
      assign t_i   = in_t;
      assign acc_i = '0;
      assign ql_i  = '0;
      assign q_i   = '0;
    end else begin : g_rest
      assign ctl_i = ctl_r[s-1];
      assign len_i = len_r[s-1];
      assign t_i   = t_r[s-1];
      assign acc_i = acc_r[s-1];
      assign ql_i  = ql_r[s-1];
      assign q_i   = q_r[s-1];
    end

    always_comb begin
      for (int c = 0; c < NCOORD; c++) begin
        cand[c] = acc_i[c] + (ACC_W'(ql_i[c]) << (J + 1)) + (ACC_W'(len_i) << (2 * J));
        if (cand[c] <= ACC_W'(t_i[c])) begin
          acc_n[c] = cand[c];
          ql_n[c]  = ql_i[c] + (QL_W'(len_i) << J);
          q_n[c]   = q_i[c] | (Q_W'(1) << J);
        end else begin
          acc_n[c] = acc_i[c];
          ql_n[c]  = ql_i[c];
          q_n[c]   = q_i[c];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        ctl_r[s] <= ctl_i;
        len_r[s] <= len_i;
        t_r[s]   <= t_i;
        acc_r[s] <= acc_n;
        ql_r[s]  <= ql_n;
        q_r[s]   <= q_n;
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v[Q_W];
  assign out_ctl   = ctl_r[Q_W];
  assign out_q     = q_r[Q_W];

  `APNL_ASSERT_SAME(a_arc_len_nonzero, in_valid && (in_ctl.kind == KIND_ARC), in_len2 != '0, "arc request with zero length")
  `APNL_ASSERT_SAME(a_q_within_radius, v[Q_W] && (ctl_r[Q_W].kind == KIND_ARC), (q_r[Q_W][0] <= radius) && (q_r[Q_W][1] <= radius) && (q_r[Q_W][2] <= radius), "quotient above radius")
  `APNL_ASSERT_NEXT(a_stall_holds, v[Q_W] && !out_ready, v[Q_W] && (q_r[Q_W] == $past(q_r[Q_W])) && (ctl_r[Q_W] == $past(ctl_r[Q_W])), "stalled result changed")

endmodule

// File: hdl/apnl_out.sv
module apnl_out import apnl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  ctl_t        in_ctl,
  input  qvec_t       in_q,
  apnl_out_if.source  point
);

  logic [NCOORD-1:0][COORD_W-1:0] pt;
  logic [STAT_W-1:0]              st;

  always_comb begin
    logic [Q_W-1:0] mag;
    mag = '0;
    pt  = '0;
    st  = STAT_OK;
    case (in_ctl.kind)
      KIND_ARC: begin
        for (int c = 0; c < NCOORD; c++) begin
          if (in_ctl.neg[c]) begin
            mag   = (in_q[c] > NEG_MAG_MAX) ? NEG_MAG_MAX : in_q[c];
            pt[c] = COORD_W'('0 - mag);
          end else begin
            pt[c] = (in_q[c] > POS_MAG_MAX) ? POS_MAG_MAX : in_q[c];
          end
        end
      end
      KIND_START: pt = cfg.start_pt;
      KIND_END:   pt = cfg.end_pt;
      KIND_RANGE: st = STAT_RANGE;
      KIND_DEGEN: st = STAT_DEGEN;
      default:    st = STAT_OK;
    endcase
  end

  logic                           ov;
  logic                           en;
  logic [NCOORD-1:0][COORD_W-1:0] pt_r;
  logic [STAT_W-1:0]              st_r;
  logic                           fin_r;

  assign en       = !ov || point.ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_r  <= pt;
      st_r  <= st;
      fin_r <= in_ctl.is_final;
    end
  end

  assign point.valid        = ov;
  assign point.point_x      = $signed(pt_r[0]);
  assign point.point_y      = $signed(pt_r[1]);
  assign point.point_z      = $signed(pt_r[2]);
  assign point.point_status = st_r;
  assign point.is_final     = fin_r;

endmodule

// File: hdl/arc_point_normalized_lerp.sv
// Arc point generator: for step index i of k segments it returns
// radius * v / |v| with v = (k-i)*start + i*end, truncated toward zero and
// saturated to signed Q15.4; index 0 gives the start point, index k the end
// point, a zero direction gives status 1 and an index above k status 2. One
// request is taken every clock while the output is not stalled. Five stages
// form the direction, its squared length and the squared radius product,
// twenty stages resolve one quotient bit each by an exact compare of
// q^2*|v|^2 against (radius*v_c)^2, and one stage saturates into the output
// register. The user must write registers through wr_en / wr_index / wr_data
// only while no request is in flight; the block itself does not enforce this.
module arc_point_normalized_lerp import apnl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [COORD_W-1:0]   wr_data,
  apnl_in_if.sink              step,
  apnl_out_if.source           point
);

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_pt      <= '0;
      cfg.end_pt        <= '0;
      cfg.radius        <= '0;
      cfg.segment_count <= SEG_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_START_X: cfg.start_pt[0]    <= wr_data;
        CFG_START_Y: cfg.start_pt[1]    <= wr_data;
        CFG_START_Z: cfg.start_pt[2]    <= wr_data;
        CFG_END_X:   cfg.end_pt[0]      <= wr_data;
        CFG_END_Y:   cfg.end_pt[1]      <= wr_data;
        CFG_END_Z:   cfg.end_pt[2]      <= wr_data;
        CFG_RADIUS:  cfg.radius         <= wr_data;
        CFG_SEGS:    cfg.segment_count  <= wr_data[IDX_W-1:0];
        default:     cfg.radius         <= cfg.radius;
      endcase
    end
  end

  logic             f_valid, f_ready;
  ctl_t             f_ctl;
  logic [LEN_W-1:0] f_len2;
  tvec_t            f_t;

  logic             s_valid, s_ready;
  ctl_t             s_ctl;
  qvec_t            s_q;

  apnl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (step.valid),
    .in_ready   (step.ready),
    .step_index (step.step_index),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .out_ctl    (f_ctl),
    .out_len2   (f_len2),
    .out_t      (f_t)
  );

  apnl_search u_search (
    .clk       (clk),
    .rst       (rst),
    .radius    (cfg.radius),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_ctl    (f_ctl),
    .in_len2   (f_len2),
    .in_t      (f_t),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_ctl   (s_ctl),
    .out_q     (s_q)
  );

  apnl_out u_out (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_valid),
    .in_ready (s_ready),
    .in_ctl   (s_ctl),
    .in_q     (s_q),
    .point    (point)
  );

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import apnl_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [STAT_W-1:0]         status;
    logic                      is_final;
  } arc_point_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = CFG_START_X;
  logic [COORD_W-1:0]   wr_data = '0;

  apnl_in_if  step_ch ();
  apnl_out_if point_ch ();

  arc_point_normalized_lerp dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .step     (step_ch.sink),
    .point    (point_ch.source)
  );

  always #1 clk = ~clk;

  logic signed [COORD_W-1:0] arc_start [3];
  logic signed [COORD_W-1:0] arc_end [3];
  logic [COORD_W-1:0]        arc_radius;
  logic [IDX_W-1:0]          arc_segs;

  arc_point_t pending_points [$];
  int errors = 0;
  int points_checked = 0;
  int burst_left = 0;
  bit stall_on = 1'b0;
  int stall_phase = 0;

  function automatic logic [COORD_W-1:0] scale_coord(longint vc, logic [63:0] len2);
    logic [127:0] mag, target, prod, lo, hi, mid;
    mag = (vc < 0) ? -vc : vc;
    target = ({108'b0, arc_radius} * {108'b0, arc_radius}) * (mag * mag);
    lo = 0;
    hi = arc_radius;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      prod = (mid * mid) * {64'b0, len2};
      if (prod <= target) lo = mid;
      else hi = mid - 1;
    end
    if (vc < 0) begin
      if (lo > 128'd524288) lo = 128'd524288;
      return -lo[COORD_W-1:0];
    end
    if (lo > 128'd524287) lo = 128'd524287;
    return lo[COORD_W-1:0];
  endfunction

  function automatic arc_point_t predict_point(logic [IDX_W-1:0] idx);
    arc_point_t p;
    longint a, b, v [3];
    logic [63:0] len2;
    p.x = '0; p.y = '0; p.z = '0;
    p.status = STAT_OK;
    p.is_final = (idx == arc_segs);
    if (idx == 0) begin
      p.x = arc_start[0]; p.y = arc_start[1]; p.z = arc_start[2];
    end else if (idx == arc_segs) begin
      p.x = arc_end[0]; p.y = arc_end[1]; p.z = arc_end[2];
    end else if (idx > arc_segs) begin
      p.status = STAT_RANGE;
    end else begin
      a = longint'(arc_segs) - longint'(idx);
      b = longint'(idx);
      for (int c = 0; c < 3; c++) v[c] = a * longint'(arc_start[c]) + b * longint'(arc_end[c]);
      len2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      if (len2 == 0) p.status = STAT_DEGEN;
      else begin
        p.x = scale_coord(v[0], len2);
        p.y = scale_coord(v[1], len2);
        p.z = scale_coord(v[2], len2);
      end
    end
    return p;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= COORD_W'(val);
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      CFG_START_X: arc_start[0] = COORD_W'(val);
      CFG_START_Y: arc_start[1] = COORD_W'(val);
      CFG_START_Z: arc_start[2] = COORD_W'(val);
      CFG_END_X:   arc_end[0] = COORD_W'(val);
      CFG_END_Y:   arc_end[1] = COORD_W'(val);
      CFG_END_Z:   arc_end[2] = COORD_W'(val);
      CFG_RADIUS:  arc_radius = COORD_W'(val);
      CFG_SEGS:    arc_segs = IDX_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_arc(int sx, int sy, int sz, int ex, int ey, int ez, int r, int k);
    write_reg(CFG_START_X, sx);
    write_reg(CFG_START_Y, sy);
    write_reg(CFG_START_Z, sz);
    write_reg(CFG_END_X, ex);
    write_reg(CFG_END_Y, ey);
    write_reg(CFG_END_Z, ez);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_SEGS, k);
  endtask

  task automatic send_step(int idx);
    int gap;
    step_ch.valid <= 1'b1;
    step_ch.step_index <= IDX_W'(idx);
    do @(posedge clk); while (!step_ch.ready);
    pending_points.insert(pending_points.size(), predict_point(IDX_W'(idx)));
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      step_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain;
    step_ch.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // output point checker
  always @(posedge clk) begin
    arc_point_t exp_p;
    if (!rst && point_ch.valid && point_ch.ready) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point x=%0d y=%0d z=%0d", $time,
                 point_ch.point_x, point_ch.point_y, point_ch.point_z);
        errors++;
      end else begin
        exp_p = pending_points.pop_front();
        points_checked++;
        if (point_ch.point_x !== exp_p.x || point_ch.point_y !== exp_p.y ||
            point_ch.point_z !== exp_p.z || point_ch.point_status !== exp_p.status ||
            point_ch.is_final !== exp_p.is_final) begin
          $display("%0t: expected x=%0d y=%0d z=%0d st=%0d fin=%0b", $time,
                   exp_p.x, exp_p.y, exp_p.z, exp_p.status, exp_p.is_final);
          $display("%0t: actual   x=%0d y=%0d z=%0d st=%0d fin=%0b", $time,
                   point_ch.point_x, point_ch.point_y, point_ch.point_z,
                   point_ch.point_status, point_ch.is_final);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 64;
    if (!stall_on || stall_phase < 16) point_ch.ready <= 1'b1;
    else point_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic test_reset_values;
    int idxs [5] = '{0, 50, 100, 101, 1023};
    foreach (idxs[n]) send_step(idxs[n]);
    drain();
  endtask

  task automatic test_extremes;
    set_arc(524287, -524288, 1000, -524288, 524287, -1, 1048575, 1023);
    send_step(0); send_step(1); send_step(511); send_step(1022); send_step(1023);
    drain();
    set_arc(-524288, -524288, -524288, 524287, 524287, 524287, 0, 1);
    send_step(0); send_step(1); send_step(2); send_step(1023);
    drain();
  endtask

  task automatic test_degenerate;
    set_arc(16, -32, 48, -16, 32, -48, 320, 4);
    send_step(1); send_step(2); send_step(3); send_step(4); send_step(5);
    drain();
    set_arc(0, 0, 0, 0, 0, 0, 1048575, 2);
    send_step(1); send_step(0); send_step(2);
    drain();
  endtask

  function automatic int rand_coord(bit narrow);
    if (narrow) return $signed($urandom_range(0, 4095)) - 2048;
    case ($urandom_range(0, 5))
      0: return 524287;
      1: return -524288;
      default: return int'($urandom_range(0, 1048575)) - 524288;
    endcase
  endfunction

  task automatic test_random_arcs;
    int k, r, idx;
    bit narrow;
    for (int ph = 0; ph < 10; ph++) begin
      stall_on = ph[0];
      narrow = ($urandom_range(0, 2) == 0);
      k = (ph == 9) ? 1023 : (ph == 4 ? 1 : $urandom_range(1, 64));
      case ($urandom_range(0, 4))
        0: r = 1048575;
        1: r = $urandom_range(0, 15);
        default: r = $urandom_range(0, 1048575);
      endcase
      set_arc(rand_coord(narrow), rand_coord(narrow), rand_coord(narrow),
              rand_coord(narrow), rand_coord(narrow), rand_coord(narrow), r, k);
      for (int n = 0; n < 80; n++) begin
        case ($urandom_range(0, 9))
          0: idx = $urandom_range(0, 1023);
          1: idx = (k < 1023) ? $urandom_range(k + 1, 1023) : k;
          2: idx = $urandom_range(0, 1) ? 0 : k;
          default: idx = $urandom_range(0, k);
        endcase
        send_step(idx);
      end
      drain();
    end
  endtask

  initial begin
    step_ch.valid = 1'b0;
    step_ch.step_index = '0;
    point_ch.ready = 1'b1;
    foreach (arc_start[c]) begin
      arc_start[c] = '0;
      arc_end[c] = '0;
    end
    arc_radius = '0;
    arc_segs = SEG_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_extremes();
    test_degenerate();
    test_random_arcs();
    $display("Checked %0d arc points over reset, extreme, degenerate and random arcs,",
             points_checked);
    $display("with input gaps and output stalls; %0d mismatches.", errors);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
